### hdl/rsi_pkg.sv
// rsi_pkg: widths, register indexes, reset values, codes and the
// controller/datapath interface structs of the RSI threshold signal block.
// No dependencies.
`default_nettype none

package rsi_pkg;

  localparam int PERIOD_W       = 8;
  localparam int LEVEL_W        = 23;
  localparam int RSI_W          = 23;
  localparam int AVG_W          = 56;
  localparam int FRAC_W         = 16;
  localparam int NUM_W          = 64;
  localparam int REM_W          = AVG_W + 1;
  localparam int STEP_W         = $clog2(NUM_W + 1);
  localparam int SIG_W          = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 23;
  localparam int DEF_PRICE_BITS = 32;
  localparam int MAX_PERIOD     = 255;
  localparam int SCALE_W        = 7;
  localparam int RSI_STEPS      = RSI_W;
  localparam int GL_W           = AVG_W + SCALE_W;

  localparam logic [SCALE_W-1:0] RSI_SCALE = SCALE_W'(100);
  localparam logic [RSI_W-1:0]   RSI_FULL  = RSI_W'(100 << FRAC_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(14);
  localparam logic [LEVEL_W-1:0]  OVERSOLD_RST   = LEVEL_W'(1966080);
  localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RST = LEVEL_W'(4587520);

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSOLD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OVERBOUGHT = CFG_IDX_W'(2);

  localparam logic [SIG_W-1:0] SIG_NONE = SIG_W'(0);
  localparam logic [SIG_W-1:0] SIG_BUY  = SIG_W'(1);
  localparam logic [SIG_W-1:0] SIG_SELL = SIG_W'(2);

  localparam logic [1:0] DIV_GAIN = 2'd0;
  localparam logic [1:0] DIV_LOSS = 2'd1;
  localparam logic [1:0] DIV_RSI  = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       prep;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_wr;
    logic       rsi_prep;
    logic       load_out;
  } rsi_cmd_t;

  typedef struct packed {
    logic need_div;
    logic loss_zero;
    logic div_done;
  } rsi_stat_t;

endpackage

`default_nettype wire

### hdl/rsi_div.sv
// rsi_div: restoring divider, one quotient bit per cycle, preloadable remainder.
// Depends on rsi_pkg.
`default_nettype none

module rsi_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rsi_pkg::REM_W-1:0]  rem_init,
  input  wire logic [rsi_pkg::NUM_W-1:0]  dvd,
  input  wire logic [rsi_pkg::REM_W-1:0]  divisor,
  input  wire logic [rsi_pkg::STEP_W-1:0] steps,
  output logic                           done,
  output logic [rsi_pkg::NUM_W-1:0]       quot
);
  import rsi_pkg::*;

  logic [REM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dvd_r;
  logic [REM_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[NUM_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dvd;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

`default_nettype wire

### hdl/rsi_dp.sv
// rsi_dp: series state, gain/loss averaging, RSI and signal datapath,
// output register. Depends on rsi_pkg and rsi_div.
`default_nettype none

module rsi_dp #(
  parameter int PRICE_BITS = rsi_pkg::DEF_PRICE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rsi_pkg::rsi_cmd_t            cmd,
  output rsi_pkg::rsi_stat_t                stat,
  input  wire logic [PRICE_BITS-1:0]        in_price,
  input  wire logic                         in_series_start,
  input  wire logic [rsi_pkg::PERIOD_W-1:0] period,
  input  wire logic [rsi_pkg::LEVEL_W-1:0]  oversold,
  input  wire logic [rsi_pkg::LEVEL_W-1:0]  overbought,
  output logic [rsi_pkg::RSI_W-1:0]         out_rsi,
  output logic                              out_rsi_valid,
  output logic [rsi_pkg::SIG_W-1:0]         out_signal,
  output logic                              out_config_fault
);
  import rsi_pkg::*;

  logic [PRICE_BITS-1:0] price_r;
  logic                  start_r;
  logic [PRICE_BITS-1:0] last_price_r;
  logic                  have_r;
  logic [PERIOD_W-1:0]   cnt_r;
  logic [AVG_W-1:0]      gain_avg_r;
  logic [AVG_W-1:0]      loss_avg_r;
  logic [RSI_W-1:0]      prev_rsi_r;
  logic                  prev_valid_r;
  logic [NUM_W-1:0]      num_g_r;
  logic [NUM_W-1:0]      num_l_r;
  logic [GL_W-1:0]       gl_r;
  logic [REM_W-1:0]      dsum_r;
  logic [RSI_W-1:0]      rsi_r;
  logic                  res_valid_r;
  logic [RSI_W-1:0]      out_rsi_r;
  logic                  out_rsi_valid_r;
  logic [SIG_W-1:0]      out_signal_r;
  logic                  out_fault_r;

  logic [PERIOD_W-1:0]   p_eff;
  logic [PERIOD_W-1:0]   pm1;
  logic                  have;
  logic [PERIOD_W-1:0]   cnt;
  logic [PERIOD_W-1:0]   cnt_inc;
  logic [AVG_W-1:0]      gavg;
  logic [AVG_W-1:0]      lavg;
  logic [PRICE_BITS-1:0] gain;
  logic [PRICE_BITS-1:0] loss;
  logic [NUM_W-1:0]      gshift;
  logic [NUM_W-1:0]      lshift;
  logic [AVG_W-1:0]      sum_g;
  logic [AVG_W-1:0]      sum_l;
  logic [NUM_W-1:0]      prod_g;
  logic [NUM_W-1:0]      prod_l;
  logic [NUM_W-1:0]      smooth_g;
  logic [NUM_W-1:0]      smooth_l;
  logic                  below;
  logic                  need_div;
  logic                  fault;
  logic [SIG_W-1:0]      sig;
  logic [RSI_STEPS-1:0]  n_lo;

  logic [REM_W-1:0]      div_rem;
  logic [NUM_W-1:0]      div_dvd;
  logic [REM_W-1:0]      div_dsr;
  logic [STEP_W-1:0]     div_steps;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quot;

  always_comb begin
    p_eff = period;
    if (period == '0) begin
      p_eff = PERIOD_W'(1);
    end else if (int'(period) > MAX_PERIOD) begin
      p_eff = PERIOD_W'(MAX_PERIOD);
    end
    pm1 = p_eff - 1'b1;
  end

  always_comb begin
    have     = have_r & ~start_r;
    cnt      = start_r ? '0 : cnt_r;
    gavg     = start_r ? '0 : gain_avg_r;
    lavg     = start_r ? '0 : loss_avg_r;
    gain     = (price_r > last_price_r) ? price_r - last_price_r : '0;
    loss     = (price_r < last_price_r) ? last_price_r - price_r : '0;
    gshift   = NUM_W'(gain) << FRAC_W;
    lshift   = NUM_W'(loss) << FRAC_W;
    sum_g    = gavg + gshift[AVG_W-1:0];
    sum_l    = lavg + lshift[AVG_W-1:0];
    prod_g   = gavg * pm1;
    prod_l   = lavg * pm1;
    smooth_g = prod_g + gshift;
    smooth_l = prod_l + lshift;
    below    = cnt < p_eff;
    cnt_inc  = cnt + 1'b1;
    need_div = have && (!below || cnt_inc == p_eff);
  end

  assign fault = oversold >= overbought;

  always_comb begin
    sig = SIG_NONE;
    if (res_valid_r && prev_valid_r && !fault) begin
      if (prev_rsi_r <= oversold && rsi_r > oversold) begin
        sig = SIG_BUY;
      end else if (prev_rsi_r >= overbought && rsi_r < overbought) begin
        sig = SIG_SELL;
      end
    end
  end

  always_comb begin
    n_lo = {gl_r[RSI_STEPS-FRAC_W-1:0], {FRAC_W{1'b0}}};
    case (cmd.div_sel)
      DIV_RSI: begin
        div_rem   = REM_W'(gl_r >> (RSI_STEPS - FRAC_W));
        div_dvd   = {n_lo, {(NUM_W - RSI_STEPS){1'b0}}};
        div_dsr   = dsum_r;
        div_steps = STEP_W'(RSI_STEPS);
      end
      DIV_LOSS: begin
        div_rem   = '0;
        div_dvd   = num_l_r;
        div_dsr   = REM_W'(p_eff);
        div_steps = STEP_W'(NUM_W);
      end
      default: begin
        div_rem   = '0;
        div_dvd   = num_g_r;
        div_dsr   = REM_W'(p_eff);
        div_steps = STEP_W'(NUM_W);
      end
    endcase
  end

  rsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (div_rem),
    .dvd      (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_price_r <= '0;
      have_r       <= 1'b0;
      cnt_r        <= '0;
      gain_avg_r   <= '0;
      loss_avg_r   <= '0;
      prev_rsi_r   <= '0;
      prev_valid_r <= 1'b0;
    end else if (cmd.prep) begin
      if (start_r) begin
        prev_rsi_r   <= '0;
        prev_valid_r <= 1'b0;
      end
      last_price_r <= price_r;
      have_r       <= 1'b1;
      if (!have) begin
        cnt_r      <= cnt;
        gain_avg_r <= gavg;
        loss_avg_r <= lavg;
      end else if (below) begin
        cnt_r      <= cnt_inc;
        gain_avg_r <= sum_g;
        loss_avg_r <= sum_l;
      end else begin
        cnt_r <= p_eff;
      end
    end else if (cmd.div_wr) begin
      if (cmd.div_sel == DIV_GAIN) begin
        gain_avg_r <= div_quot[AVG_W-1:0];
      end else if (cmd.div_sel == DIV_LOSS) begin
        loss_avg_r <= div_quot[AVG_W-1:0];
      end
    end else if (cmd.load_out && res_valid_r) begin
      prev_rsi_r   <= rsi_r;
      prev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      price_r <= in_price;
      start_r <= in_series_start;
    end
    if (cmd.prep) begin
      num_g_r     <= below ? NUM_W'(sum_g) : smooth_g;
      num_l_r     <= below ? NUM_W'(sum_l) : smooth_l;
      res_valid_r <= need_div;
      rsi_r       <= '0;
    end
    if (cmd.rsi_prep) begin
      gl_r   <= gain_avg_r * RSI_SCALE;
      dsum_r <= REM_W'(gain_avg_r) + REM_W'(loss_avg_r);
      if (loss_avg_r == '0) begin
        rsi_r <= RSI_FULL;
      end
    end
    if (cmd.div_wr && cmd.div_sel == DIV_RSI) begin
      rsi_r <= div_quot[RSI_W-1:0];
    end
    if (cmd.load_out) begin
      out_rsi_r       <= rsi_r;
      out_rsi_valid_r <= res_valid_r;
      out_signal_r    <= sig;
      out_fault_r     <= fault;
    end
  end

  assign stat.need_div  = need_div;
  assign stat.loss_zero = loss_avg_r == '0;
  assign stat.div_done  = div_done;

  assign out_rsi          = out_rsi_r;
  assign out_rsi_valid    = out_rsi_valid_r;
  assign out_signal       = out_signal_r;
  assign out_config_fault = out_fault_r;

endmodule

`default_nettype wire

### hdl/rsi_ctrl.sv
// rsi_ctrl: sequencer for one price bar and the output valid flag.
// Depends on rsi_pkg.
`default_nettype none

module rsi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rsi_pkg::rsi_stat_t stat,
  output rsi_pkg::rsi_cmd_t       cmd
);
  import rsi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DGS   = 4'd2;
  localparam logic [3:0] S_DGW   = 4'd3;
  localparam logic [3:0] S_DLS   = 4'd4;
  localparam logic [3:0] S_DLW   = 4'd5;
  localparam logic [3:0] S_RPREP = 4'd6;
  localparam logic [3:0] S_RS    = 4'd7;
  localparam logic [3:0] S_RW    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.need_div ? S_DGS : S_FIN;
      end
      S_DGS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GAIN;
        state_nxt     = S_DGW;
      end
      S_DGW: begin
        cmd.div_sel = DIV_GAIN;
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_DLS;
        end
      end
      S_DLS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LOSS;
        state_nxt     = S_DLW;
      end
      S_DLW: begin
        cmd.div_sel = DIV_LOSS;
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_RPREP;
        end
      end
      S_RPREP: begin
        cmd.rsi_prep = 1'b1;
        state_nxt    = stat.loss_zero ? S_FIN : S_RS;
      end
      S_RS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RSI;
        state_nxt     = S_RW;
      end
      S_RW: begin
        cmd.div_sel = DIV_RSI;
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hdl/rsi_threshold_signal_top.sv
// rsi_threshold_signal_top: Wilder RSI with oversold/overbought crossing signals.
// Holds the configuration registers; depends on rsi_pkg, rsi_ctrl, rsi_dp.
//
//   port group  dir  handshake             payload
//   in_         in   in_valid / in_ready   in_price, in_series_start
//   out_        out  out_valid / out_ready out_rsi, out_rsi_valid, out_signal,
//                                          out_config_fault
//   cfg_        in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A bar that completes or extends the averages runs two 64-step divisions by
// the period and one 23-step RSI division, all on one shared bit-serial
// divider; the RSI division is skipped when the average loss is zero, and a
// bar that gives no RSI uses no division. One bar is in flight at a time; the
// next beat is taken while the previous result waits in the output register.
// Synchronous active-low reset restores the register defaults and clears the
// series. cfg_ready is always high.
`default_nettype none

module rsi_threshold_signal_top #(
  parameter int PRICE_BITS = rsi_pkg::DEF_PRICE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [PRICE_BITS-1:0]          in_price,
  input  wire logic                           in_series_start,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rsi_pkg::RSI_W-1:0]           out_rsi,
  output logic                                out_rsi_valid,
  output logic [rsi_pkg::SIG_W-1:0]           out_signal,
  output logic                                out_config_fault,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsi_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic [LEVEL_W-1:0]  oversold_r;
  logic [LEVEL_W-1:0]  overbought_r;
  rsi_cmd_t            cmd;
  rsi_stat_t           stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RST;
      oversold_r   <= OVERSOLD_RST;
      overbought_r <= OVERBOUGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PERIOD:     period_r     <= cfg_data[PERIOD_W-1:0];
        CFG_OVERSOLD:   oversold_r   <= cfg_data[LEVEL_W-1:0];
        CFG_OVERBOUGHT: overbought_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  rsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsi_dp #(
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_price         (in_price),
    .in_series_start  (in_series_start),
    .period           (period_r),
    .oversold         (oversold_r),
    .overbought       (overbought_r),
    .out_rsi          (out_rsi),
    .out_rsi_valid    (out_rsi_valid),
    .out_signal       (out_signal),
    .out_config_fault (out_config_fault)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a bar is in flight");

  a_rsi_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsi_valid) |-> (out_rsi == '0))
    else $error("rsi nonzero without a valid average");

  a_signal_needs_rsi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_signal != SIG_NONE) |-> (out_rsi_valid && !out_config_fault))
    else $error("signal raised without valid rsi or under threshold fault");

  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsi <= RSI_FULL))
    else $error("rsi above full scale");
`endif

endmodule

`default_nettype wire
